@@ hw/rtl/cfd_pkg.sv @@
package cfd_pkg;

  localparam int FRAME_LENGTH = 10;
  localparam int CRC_SPAN     = 7;
  localparam int POS_W        = $clog2(FRAME_LENGTH);
  localparam int CMD_DEPTH    = 2;
  localparam int RES_DEPTH    = 2;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;
  localparam logic [1:0]  OPEN_LOOP_SELECT = 2'd1;
  localparam logic [5:0]  MAX_MODE         = 6'd10;
  localparam logic [13:0] PWM_SCALE        = 14'd10;
  localparam logic [11:0] TARGET_SCALE     = 12'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HEADER_WORD = 2'd0,
    REG_FOOTER_BYTE = 2'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FRAMING = 2'd1,
    STAT_CRC     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SIGN_ZERO = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_t;

  typedef struct packed {
    sign_t a;
    sign_t b;
    sign_t c;
    sign_t d;
  } wheel_signs_t;

  // Classified frame handed from the front to the back.
  typedef struct packed {
    status_t     status;
    logic [9:0]  speed;
    logic [5:0]  mode;
    logic [1:0]  sel;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic               closed_loop;
    logic [3:0]         direction_mode;
    logic               stop_request;
    logic [13:0]        pwm_duty;
    logic signed [12:0] wheel_a;
    logic signed [12:0] wheel_b;
    logic signed [12:0] wheel_c;
    logic signed [12:0] wheel_d;
  } res_t;

  // Mecanum sign pattern per movement mode.
  function automatic wheel_signs_t mode_signs(input logic [3:0] mode);
    wheel_signs_t s;
    s = '{SIGN_ZERO, SIGN_ZERO, SIGN_ZERO, SIGN_ZERO};
    case (mode)
      4'd1:    s = '{SIGN_POS,  SIGN_NEG,  SIGN_POS,  SIGN_NEG};
      4'd2:    s = '{SIGN_POS,  SIGN_ZERO, SIGN_POS,  SIGN_ZERO};
      4'd3:    s = '{SIGN_POS,  SIGN_POS,  SIGN_POS,  SIGN_POS};
      4'd4:    s = '{SIGN_ZERO, SIGN_NEG,  SIGN_ZERO, SIGN_NEG};
      4'd5:    s = '{SIGN_NEG,  SIGN_POS,  SIGN_NEG,  SIGN_POS};
      4'd6:    s = '{SIGN_NEG,  SIGN_ZERO, SIGN_NEG,  SIGN_ZERO};
      4'd7:    s = '{SIGN_NEG,  SIGN_NEG,  SIGN_NEG,  SIGN_NEG};
      4'd8:    s = '{SIGN_ZERO, SIGN_NEG,  SIGN_ZERO, SIGN_NEG};
      4'd9:    s = '{SIGN_NEG,  SIGN_NEG,  SIGN_POS,  SIGN_POS};
      4'd10:   s = '{SIGN_POS,  SIGN_POS,  SIGN_NEG,  SIGN_NEG};
      default: s = '{SIGN_ZERO, SIGN_ZERO, SIGN_ZERO, SIGN_ZERO};
    endcase
    return s;
  endfunction

endpackage

@@ hw/rtl/cfd_fifo.sv @@
module cfd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

endmodule

@@ hw/rtl/cfd_front.sv @@
module cfd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [cfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  input  logic                           push,
  input  logic [7:0]                     rx_byte,
  output logic                           full,
  output logic                           cmd_push,
  output cfd_pkg::cmd_t                  cmd_data,
  input  logic                           cmd_full
);
  import cfd_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);
  localparam logic [POS_W-1:0] CRC_END  = POS_W'(CRC_SPAN);

  logic [15:0]      header_word_r;
  logic [7:0]       footer_byte_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       frame_r [FRAME_LENGTH-1];
  logic             accept, last_byte;
  logic [15:0]      hdr, chk;

  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Only the closing byte of a frame needs room in the command queue.
  assign last_byte = (pos_r == LAST_POS);
  assign full      = last_byte && cmd_full;
  assign accept    = push && !full;
  assign cmd_push  = accept && last_byte;

  assign hdr = {frame_r[0], frame_r[1]};
  assign chk = {frame_r[FRAME_LENGTH-2], frame_r[FRAME_LENGTH-3]};

  always_comb begin
    cmd_data.speed = {frame_r[4][1:0], frame_r[5]};
    cmd_data.mode  = frame_r[4][7:2];
    cmd_data.sel   = frame_r[6][1:0];
    if (hdr != header_word_r || rx_byte != footer_byte_r) begin
      cmd_data.status = STAT_FRAMING;
    end else if (crc_r != chk) begin
      cmd_data.status = STAT_CRC;
    end else begin
      cmd_data.status = STAT_OK;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    if (accept) begin
      if (last_byte) begin
        pos_nxt = '0;
        crc_nxt = CRC_INIT;
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r < CRC_END) begin
          crc_nxt = crc_update(crc_r, rx_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      crc_r         <= CRC_INIT;
      header_word_r <= '0;
      footer_byte_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_HEADER_WORD: header_word_r <= cfg_data;
          REG_FOOTER_BYTE: footer_byte_r <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // The closing byte is checked live, so only the leading bytes are stored.
  for (genvar g = 0; g < FRAME_LENGTH - 1; g++) begin : g_store
    always_ff @(posedge clk) begin
      if (accept && pos_r == POS_W'(g)) begin
        frame_r[g] <= rx_byte;
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("byte position out of frame");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |=> (pos_r == '0) && (crc_r == CRC_INIT))
    else $error("framing not restarted after closing byte");

endmodule

@@ hw/rtl/cfd_back.sv @@
module cfd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_empty,
  input  cfd_pkg::cmd_t cmd_data,
  output logic          cmd_pop,
  output logic          res_push,
  output cfd_pkg::res_t res_data,
  input  logic          res_full
);
  import cfd_pkg::*;

  logic signed [12:0] tgt_a_r, tgt_b_r, tgt_c_r, tgt_d_r;
  logic signed [12:0] tgt_a_nxt, tgt_b_nxt, tgt_c_nxt, tgt_d_nxt;
  logic [11:0]        mag;
  logic               mode_ok;
  wheel_signs_t       signs;

  function automatic logic signed [12:0] signed_target(input sign_t s,
                                                       input logic [11:0] m);
    logic signed [12:0] v;
    case (s)
      SIGN_POS: v = $signed({1'b0, m});
      SIGN_NEG: v = -$signed({1'b0, m});
      default:  v = '0;
    endcase
    return v;
  endfunction

  assign cmd_pop  = !cmd_empty && !res_full;
  assign res_push = cmd_pop;
  assign mode_ok  = (cmd_data.mode <= MAX_MODE);
  assign mag      = 12'(cmd_data.speed) * TARGET_SCALE;
  assign signs    = mode_signs(cmd_data.mode[3:0]);

  always_comb begin
    tgt_a_nxt = tgt_a_r;
    tgt_b_nxt = tgt_b_r;
    tgt_c_nxt = tgt_c_r;
    tgt_d_nxt = tgt_d_r;

    res_data.status         = cmd_data.status;
    res_data.closed_loop    = 1'b0;
    res_data.direction_mode = '0;
    res_data.stop_request   = 1'b0;
    res_data.pwm_duty       = '0;

    if (cmd_data.status == STAT_OK) begin
      res_data.direction_mode = mode_ok ? cmd_data.mode[3:0] : 4'd0;
      res_data.stop_request   = !mode_ok || (cmd_data.mode == '0);
      if (cmd_data.sel == OPEN_LOOP_SELECT) begin
        res_data.pwm_duty = 14'(cmd_data.speed) * PWM_SCALE;
      end else begin
        res_data.closed_loop = 1'b1;
        // Out-of-range mode is a stop: hold the old targets.
        if (mode_ok && cmd_pop) begin
          tgt_a_nxt = signed_target(signs.a, mag);
          tgt_b_nxt = signed_target(signs.b, mag);
          tgt_c_nxt = signed_target(signs.c, mag);
          tgt_d_nxt = signed_target(signs.d, mag);
        end
      end
    end

    res_data.wheel_a = tgt_a_nxt;
    res_data.wheel_b = tgt_b_nxt;
    res_data.wheel_c = tgt_c_nxt;
    res_data.wheel_d = tgt_d_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_a_r <= '0;
      tgt_b_r <= '0;
      tgt_c_r <= '0;
      tgt_d_r <= '0;
    end else begin
      tgt_a_r <= tgt_a_nxt;
      tgt_b_r <= tgt_b_nxt;
      tgt_c_r <= tgt_c_nxt;
      tgt_d_r <= tgt_d_nxt;
    end
  end

  a_targets_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_pop |=> $stable({tgt_a_r, tgt_b_r, tgt_c_r, tgt_d_r}))
    else $error("wheel targets moved without a command");

endmodule

@@ hw/rtl/crc_framed_drive_command_decoder.sv @@
// Drive command frame decoder. Bytes arrive on push/full and are gathered
// into fixed 10-byte frames; framing restarts only after every tenth byte
// or a reset, there is no resynchronization. A frame passes when its first
// two bytes equal header_word (register 0, first byte in the high half),
// its last byte equals footer_byte (register 1) and the Modbus CRC-16
// (init 0xFFFF, reflected poly 0xA001) over bytes 0..6 equals byte8:byte7.
// Each frame yields exactly one result with status 0 ok, 1 header/footer
// mismatch (wins over CRC), 2 CRC mismatch. A passing frame with select 1
// drives open loop (pwm_duty = speed*10); any other select updates the four
// held wheel targets to +/-speed*3 or 0 by the mecanum pattern of the mode,
// and a mode above 10 requests a stop and holds the old targets. Targets
// are always reported as held after the frame. Rate: one byte per clock
// while full is low; the CRC takes a whole byte at once. The front (byte
// collection and frame check) and back (command execution) are decoupled
// by a command queue of CMD_DEPTH frames, results wait in a queue of
// RES_DEPTH beats. With both queues free, the closing byte's command is
// registered in the command queue, the back moves it into the result
// queue, and from there the result shows on the out_ ports; full rises
// only for a closing byte while the command queue is full. cfg_ready is
// always high; write configuration while idle.
module crc_framed_drive_command_decoder #(
  parameter int CMD_DEPTH = cfd_pkg::CMD_DEPTH,
  parameter int RES_DEPTH = cfd_pkg::RES_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data,
  // byte stream in
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      in_rx_byte,
  // results out
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      out_status,
  output logic                            out_closed_loop,
  output logic [3:0]                      out_direction_mode,
  output logic                            out_stop_request,
  output logic [13:0]                     out_pwm_duty,
  output logic signed [12:0]              out_wheel_a,
  output logic signed [12:0]              out_wheel_b,
  output logic signed [12:0]              out_wheel_c,
  output logic signed [12:0]              out_wheel_d
);
  import cfd_pkg::*;

  cmd_t                 cmd_in, cmd_out;
  logic                 cmd_push, cmd_full, cmd_pop, cmd_empty;
  res_t                 res_in, res_out;
  logic                 res_push, res_full;
  logic [$bits(cmd_t)-1:0] cmd_q;
  logic [$bits(res_t)-1:0] res_q;

  assign cfg_ready = 1'b1;

  // Front: collect bytes, run the CRC, classify the closed frame.
  cfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .rx_byte   (in_rx_byte),
    .full      (full),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in),
    .cmd_full  (cmd_full)
  );

  // Hold classified frames until the back can take them.
  cfd_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_q),
    .empty     (cmd_empty)
  );
  assign cmd_out = cmd_t'(cmd_q);

  // Back: execute the command, update the held wheel targets.
  cfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_in),
    .res_full  (res_full)
  );

  // Results wait here for the consumer.
  cfd_fifo #(.WIDTH($bits(res_t)), .DEPTH(RES_DEPTH)) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_q),
    .empty     (empty)
  );
  assign res_out = res_t'(res_q);

  assign out_status         = res_out.status;
  assign out_closed_loop    = res_out.closed_loop;
  assign out_direction_mode = res_out.direction_mode;
  assign out_stop_request   = res_out.stop_request;
  assign out_pwm_duty       = res_out.pwm_duty;
  assign out_wheel_a        = res_out.wheel_a;
  assign out_wheel_b        = res_out.wheel_b;
  assign out_wheel_c        = res_out.wheel_c;
  assign out_wheel_d        = res_out.wheel_d;

  a_no_status_three: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_status == STAT_OK || out_status == STAT_FRAMING ||
                out_status == STAT_CRC))
    else $error("undefined status on result beat");

endmodule
